// File: hdl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace unit.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_LEN_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam byte_t NEWLINE_BYTE = 8'd10;

  // configuration register indexes
  localparam cfg_idx_t CFG_SEARCH_PATTERN     = 2'd0;
  localparam cfg_idx_t CFG_SEARCH_LENGTH      = 2'd1;
  localparam cfg_idx_t CFG_REPLACEMENT_TEXT   = 2'd2;
  localparam cfg_idx_t CFG_REPLACEMENT_LENGTH = 2'd3;

  // output buffer status towards the top level
  typedef struct packed {
    logic valid;   // head entry holds a result byte
    logic last;    // head entry is the final byte of its request
    logic space;   // a full burst of results fits
  } sfr_buf_stat_t;

endpackage

// File: hdl/sfr_cell.sv
// One byte position of the sliding match window: holds a byte, takes an
// appended or shifted-in byte, and compares against its pattern lane. Uses sfr_pkg.
module sfr_cell (
  input  logic          clk_i,
  input  logic          step_i,      // an ordinary text byte was accepted
  input  logic          append_i,    // the new byte lands in this position
  input  sfr_pkg::byte_t byte_i,
  input  sfr_pkg::byte_t pat_i,
  input  logic          shift_en_i,  // a decision was made: take the neighbour's byte
  input  sfr_pkg::byte_t shift_i,
  output sfr_pkg::byte_t cur_o,      // window byte with the append applied
  output logic          eq_o
);
  import sfr_pkg::*;

  byte_t win_q, win_d;

  assign cur_o = append_i ? byte_i : win_q;
  assign eq_o  = (cur_o == pat_i);

  always_comb begin
    win_d = win_q;
    if (step_i) begin
      win_d = shift_en_i ? shift_i : cur_o;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// File: hdl/sfr_outbuf.sv
// Result buffer: takes a burst of up to LOAD_N bytes per request and plays
// them out one per cycle while pop_ready_i is high, head first. Uses sfr_pkg.
module sfr_outbuf #(
  parameter int unsigned LOAD_N = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_en_i,
  input  logic [$clog2(LOAD_N+1)-1:0]   load_cnt_i,
  input  sfr_pkg::byte_t                load_bytes_i [LOAD_N],
  input  logic                          pop_ready_i,
  output sfr_pkg::byte_t                head_o,
  output sfr_pkg::sfr_buf_stat_t        stat_o
);
  import sfr_pkg::*;

  localparam int unsigned DEPTH = 2 * LOAD_N;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  byte_t            buf_q [DEPTH];
  byte_t            buf_d [DEPTH];
  byte_t            shifted [DEPTH];
  logic [DEPTH-1:0] last_q, last_d, last_sh;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] off [DEPTH];
  logic             pop;

  assign pop  = (cnt_q != '0) && pop_ready_i;
  assign base = cnt_q - CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      shifted[i] = pop ? buf_q[i+1] : buf_q[i];
      last_sh[i] = pop ? last_q[i+1] : last_q[i];
    end
    shifted[DEPTH-1] = pop ? '0 : buf_q[DEPTH-1];
    last_sh[DEPTH-1] = pop ? 1'b0 : last_q[DEPTH-1];
  end

  // new bytes are appended behind whatever is still queued; each entry
  // carries its own end-of-request flag
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      off[i]    = CNT_W'(i) - base;
      buf_d[i]  = shifted[i];
      last_d[i] = last_sh[i];
      if (load_en_i && (CNT_W'(i) >= base) && (off[i] < CNT_W'(load_cnt_i))) begin
        last_d[i] = (off[i] == (CNT_W'(load_cnt_i) - CNT_W'(1)));
        for (int k = 0; k < LOAD_N; k++) begin
          if (off[i] == CNT_W'(k)) begin
            buf_d[i] = load_bytes_i[k];
          end
        end
      end
    end
  end

  always_comb begin
    cnt_d = base;
    if (load_en_i) begin
      cnt_d = base + CNT_W'(load_cnt_i);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = buf_q[0];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.last  = last_q[0];
  assign stat_o.space = (cnt_q <= CNT_W'(LOAD_N));

endmodule

// File: hdl/stream_find_replace_unit.sv
// Stream find-and-replace: a row of window cells matches the search pattern,
// and a result buffer serialises emitted bytes. Uses sfr_pkg, sfr_cell, sfr_outbuf.
// Result bytes of a request are registered into the result buffer on accept, behind any still queued.
// Throughput: one input byte per cycle while the result buffer has room for a
// full burst; output drains one byte per cycle while m_axis_tready_i is high, so expansion stalls the input.
// Reset (async, active low): config back to defaults, window emptied, buffer empty.
module stream_find_replace_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned MAX_REPLACE_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] in_byte
  input  logic                          s_axis_tuser_i,   // [0] end_of_input
  // output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,   // [7:0] out_byte
  output logic                          m_axis_tlast_o,   // last_of_run
  // configuration
  input  logic                          cfg_we_i,
  input  sfr_pkg::cfg_idx_t             cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sfr_pkg::*;

  localparam int unsigned MAX_RES = (MAX_PATTERN_BYTES > MAX_REPLACE_BYTES) ?
                                    MAX_PATTERN_BYTES : MAX_REPLACE_BYTES;
  localparam int unsigned FILL_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned RES_W   = $clog2(MAX_RES + 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] search_pattern_q, repl_text_q;
  logic [CFG_LEN_W-1:0]  search_length_q, repl_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_pattern_q <= '0;
      search_length_q  <= CFG_LEN_W'(1);
      repl_text_q      <= '0;
      repl_length_q    <= CFG_LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEARCH_PATTERN:     search_pattern_q <= cfg_wdata_i;
        CFG_SEARCH_LENGTH:      search_length_q  <= cfg_wdata_i[CFG_LEN_W-1:0];
        CFG_REPLACEMENT_TEXT:   repl_text_q      <= cfg_wdata_i;
        CFG_REPLACEMENT_LENGTH: repl_length_q    <= cfg_wdata_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths: zero reads as one, oversize saturates
  logic [FILL_W-1:0] slen;
  logic [RES_W-1:0]  rlen;

  always_comb begin
    if (search_length_q == '0) begin
      slen = FILL_W'(1);
    end else if (search_length_q > CFG_LEN_W'(MAX_PATTERN_BYTES)) begin
      slen = FILL_W'(MAX_PATTERN_BYTES);
    end else begin
      slen = FILL_W'(search_length_q);
    end
  end

  always_comb begin
    if (repl_length_q == '0) begin
      rlen = RES_W'(1);
    end else if (repl_length_q > CFG_LEN_W'(MAX_REPLACE_BYTES)) begin
      rlen = RES_W'(MAX_REPLACE_BYTES);
    end else begin
      rlen = RES_W'(repl_length_q);
    end
  end

  // request decode
  sfr_buf_stat_t     buf_stat;
  logic              accept, ordinary, flush;
  logic [FILL_W-1:0] fill_q, fill_d, fill_app;
  logic              pending_q, pending_d;

  assign s_axis_tready_o = buf_stat.space;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign ordinary = !s_axis_tuser_i && (s_axis_tdata_i != NEWLINE_BYTE);
  assign flush    = s_axis_tuser_i ? pending_q : (s_axis_tdata_i == NEWLINE_BYTE);
  assign fill_app = fill_q + FILL_W'(1);

  // window row
  byte_t                  cur   [MAX_PATTERN_BYTES];
  byte_t                  shin  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] eq, used;
  logic                   decide, hit;
  logic [FILL_W-1:0]      sh;

  assign decide = (fill_app >= slen);
  assign hit    = decide && (&(eq | ~used));
  assign sh     = hit ? slen : FILL_W'(1);

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    assign used[i] = (FILL_W'(i) < slen);

    // neighbour byte sh places downstream
    always_comb begin
      shin[i] = '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        if (int'(sh) + i == k) begin
          shin[i] = cur[k];
        end
      end
    end

    sfr_cell u_cell (
      .clk_i      (clk_i),
      .step_i     (accept && ordinary),
      .append_i   (ordinary && (fill_q == FILL_W'(i))),
      .byte_i     (s_axis_tdata_i),
      .pat_i      (search_pattern_q[BYTE_W*i +: BYTE_W]),
      .shift_en_i (decide),
      .shift_i    (shin[i]),
      .cur_o      (cur[i]),
      .eq_o       (eq[i])
    );
  end

  always_comb begin
    fill_d    = fill_q;
    pending_d = pending_q;
    if (accept) begin
      if (ordinary) begin
        pending_d = 1'b1;
        fill_d    = decide ? (fill_app - sh) : fill_app;
      end else if (flush) begin
        pending_d = 1'b0;
        fill_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      pending_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      pending_q <= pending_d;
    end
  end

  // result burst for this request
  byte_t            res_bytes [MAX_RES];
  logic [RES_W-1:0] res_cnt;

  for (genvar j = 0; j < MAX_RES; j++) begin : g_res
    byte_t flush_byte;
    if (j < MAX_PATTERN_BYTES) begin : g_win
      assign flush_byte = (j < int'(fill_q)) ? cur[j] :
                          ((j == int'(fill_q)) ? NEWLINE_BYTE : '0);
    end else begin : g_nl
      assign flush_byte = (j == int'(fill_q)) ? NEWLINE_BYTE : '0;
    end

    always_comb begin
      if (!ordinary) begin
        res_bytes[j] = flush_byte;
      end else if (hit) begin
        res_bytes[j] = repl_text_q[BYTE_W*j +: BYTE_W];
      end else begin
        res_bytes[j] = (j == 0) ? cur[0] : '0;
      end
    end
  end

  always_comb begin
    res_cnt = '0;
    if (ordinary) begin
      if (hit) begin
        res_cnt = rlen;
      end else if (decide) begin
        res_cnt = RES_W'(1);
      end
    end else if (flush) begin
      res_cnt = RES_W'(fill_q) + RES_W'(1);
    end
  end

  sfr_outbuf #(
    .LOAD_N (MAX_RES)
  ) u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (accept),
    .load_cnt_i   (res_cnt),
    .load_bytes_i (res_bytes),
    .pop_ready_i  (m_axis_tready_i),
    .head_o       (m_axis_tdata_o),
    .stat_o       (buf_stat)
  );

  assign m_axis_tvalid_o = buf_stat.valid;
  assign m_axis_tlast_o  = buf_stat.last;

endmodule

// File: hdl/sfr_checker.sv
// Port-level checks for stream_find_replace_unit, attached by bind.
// Uses sfr_pkg for the newline code.
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);
  import sfr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // nothing to deliver once a reset cycle has passed
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

  // a line end always produces at least the newline
  a_newline_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i &&
    (s_axis_tdata_i == NEWLINE_BYTE) |=> m_axis_tvalid_o)
    else $error("line end produced no result");

  // input only back-pressured while results are queued
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result buffer");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// File: tb/testbench.sv
// Self-checking testbench for stream_find_replace_unit: directed table, then randomised
// text phases with idle and stall patterns. Depends on sfr_pkg and the unit's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int unsigned WIN_BYTES       = 8;
  localparam int unsigned MAX_PAT         = 8;
  localparam int unsigned MAX_REP         = 8;
  localparam int unsigned MAX_OUT         = 8;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 16;
  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 38;
  localparam int unsigned MAX_REPORTS     = 40;
  // search / replacement lengths per random phase; 0 and 15 hit the clamping
  localparam int SLEN_SET [N_PHASES] = '{1, 8, 4, 0, 8, 15, 2, 3};
  localparam int RLEN_SET [N_PHASES] = '{8, 1, 0, 15, 8, 3, 5, 1};

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_byte_t;

  typedef struct packed {
    byte_t data;
    logic  eoi;
  } text_req_t;

  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] wdata;
    byte_t                 data;
    logic                  eoi;
    int                    n_typed;  // -1: predictor decides
    byte_t                 typed;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  s_valid   = 1'b0;
  byte_t                 s_data    = '0;
  logic                  s_user    = 1'b0;
  logic                  m_ready   = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_idx   = CFG_SEARCH_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_ready;
  logic                  m_valid;
  byte_t                 m_data;
  logic                  m_last;

  stream_find_replace_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // predictor copy of registers and window
  logic [CFG_DATA_W-1:0] srch_pat = '0;
  logic [CFG_LEN_W-1:0]  srch_len = 4'd1;
  logic [CFG_DATA_W-1:0] repl_txt = '0;
  logic [CFG_LEN_W-1:0]  repl_len = 4'd1;
  byte_t                 win [WIN_BYTES];
  int unsigned           win_fill = 0;
  logic                  line_open = 1'b0;

  out_byte_t   step_bytes [$];
  out_byte_t   awaited_bytes [$];
  text_req_t   text_plan [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
             awaited_bytes.size());
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    end
  endtask

  function automatic int unsigned eff_len(logic [CFG_LEN_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void emit(byte_t b);
    out_byte_t o;
    o.data = b;
    o.last = 1'b0;
    if (step_bytes.size() < MAX_OUT) step_bytes.push_back(o);
  endfunction

  function automatic void drop_front(int unsigned n);
    int unsigned k;
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (k = 0; k + n < win_fill; k++) win[k] = win[k + n];
      win_fill -= n;
    end
  endfunction

  function automatic void flush_window();
    int unsigned k;
    for (k = 0; k < win_fill && k < WIN_BYTES; k++) emit(win[k]);
    emit(NEWLINE_BYTE);
    win_fill  = 0;
    line_open = 1'b0;
  endfunction

  // bytes the unit should emit for one accepted request, into step_bytes
  function automatic void replace_step(byte_t b, logic eoi);
    int unsigned sl, rl, k;
    logic        hit;
    out_byte_t   o;
    step_bytes.delete();
    if (eoi) begin
      if (line_open) flush_window();
    end else if (b == NEWLINE_BYTE) begin
      flush_window();
    end else begin
      line_open = 1'b1;
      if (win_fill < WIN_BYTES) begin
        win[win_fill] = b;
        win_fill++;
      end
      sl = eff_len(srch_len, MAX_PAT);
      if (win_fill >= sl) begin
        hit = 1'b1;
        for (k = 0; k < sl; k++) begin
          if (win[k] != srch_pat[8*k +: 8]) hit = 1'b0;
        end
        if (hit) begin
          rl = eff_len(repl_len, MAX_REP);
          for (k = 0; k < rl; k++) emit(repl_txt[8*k +: 8]);
          drop_front(sl);
        end else begin
          emit(win[0]);
          drop_front(1);
        end
      end
    end
    if (step_bytes.size() > 0) begin
      o = step_bytes.pop_back();
      o.last = 1'b1;
      step_bytes.push_back(o);
    end
  endfunction

  // n_typed >= 0: that many copies of typed are due instead of the predicted bytes
  task automatic send_text(byte_t b, logic eoi, int n_typed, byte_t typed);
    out_byte_t o;
    int        k;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= eoi;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
    replace_step(b, eoi);
    if (n_typed < 0) begin
      foreach (step_bytes[i]) awaited_bytes.push_back(step_bytes[i]);
    end else begin
      for (k = 0; k < n_typed; k++) begin
        o.data = typed;
        o.last = (k == n_typed - 1);
        awaited_bytes.push_back(o);
      end
    end
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (awaited_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SEARCH_PATTERN:     srch_pat = val;
      CFG_SEARCH_LENGTH:      srch_len = val[CFG_LEN_W-1:0];
      CFG_REPLACEMENT_TEXT:   repl_txt = val;
      CFG_REPLACEMENT_LENGTH: repl_len = val[CFG_LEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // pattern bytes mostly from a tiny alphabet so that text built around it
  // produces hits, partial hits and overlaps
  task automatic program_phase(int slen, int rlen);
    logic [CFG_DATA_W-1:0] pat, lenw;
    int unsigned           sl, k, r;
    sl  = eff_len(slen[CFG_LEN_W-1:0], MAX_PAT);
    pat = {$urandom, $urandom};
    for (k = 0; k < sl; k++) begin
      r = $urandom_range(0, 99);
      if (r < 94) pat[8*k +: 8] = byte_t'(8'h61 + $urandom_range(0, 2));
      else if (r < 97) pat[8*k +: 8] = NEWLINE_BYTE;
    end
    write_reg(CFG_SEARCH_PATTERN, pat);
    lenw = {$urandom, $urandom};
    lenw[CFG_LEN_W-1:0] = slen[CFG_LEN_W-1:0];
    write_reg(CFG_SEARCH_LENGTH, lenw);
    write_reg(CFG_REPLACEMENT_TEXT, {$urandom, $urandom});
    lenw = {$urandom, $urandom};
    lenw[CFG_LEN_W-1:0] = rlen[CFG_LEN_W-1:0];
    write_reg(CFG_REPLACEMENT_LENGTH, lenw);
  endtask

  function automatic void plan_push(byte_t b, logic eoi);
    text_req_t t;
    t.data = b;
    t.eoi  = eoi;
    text_plan.push_back(t);
  endfunction

  // next stretch of text: whole pattern, broken pattern, line ends, end-of-input or noise
  function automatic void plan_text();
    int unsigned sl, r, k, n;
    sl = eff_len(srch_len, MAX_PAT);
    r  = $urandom_range(0, 99);
    if (r < 55) begin
      for (k = 0; k < sl; k++) plan_push(srch_pat[8*k +: 8], 1'b0);
    end else if (r < 70) begin
      n = $urandom_range(0, sl - 1);
      for (k = 0; k < n; k++) plan_push(srch_pat[8*k +: 8], 1'b0);
      plan_push(byte_t'(8'h61 + $urandom_range(0, 2)), 1'b0);
    end else if (r < 80) begin
      plan_push(NEWLINE_BYTE, 1'b0);
    end else if (r < 86) begin
      plan_push(byte_t'($urandom_range(0, 255)), 1'b1);
    end else begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) plan_push(byte_t'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = val;
    return row;
  endfunction

  function automatic stim_row_t txt_row(byte_t b, logic eoi, int n_typed, byte_t typed);
    stim_row_t row;
    row         = '0;
    row.data    = b;
    row.eoi     = eoi;
    row.n_typed = n_typed;
    row.typed   = typed;
    return row;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      m_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_byte_t want;
    if (rst_n && m_valid === 1'b1 && m_ready) begin
      results_checked++;
      if (awaited_bytes.size() == 0) begin
        report_mismatch("out_byte with no request pending", int'(m_data), -1);
      end else begin
        want = awaited_bytes.pop_front();
        if (m_data !== want.data) begin
          report_mismatch("out_byte", int'(m_data), int'(want.data));
        end
        if (m_last !== want.last) begin
          report_mismatch("last_of_run", int'(m_last), int'(want.last));
        end
      end
    end
  end

  initial begin
    stim_row_t   dir_rows [$];
    stim_row_t   row;
    text_req_t   req;
    int unsigned ph, counted, pressure_at;
    logic        ignored;

    foreach (win[i]) win[i] = '0;

    // after reset: pattern 0 of length 1, replacement 0 of length 1
    dir_rows.push_back(txt_row(8'h00, 1'b0, 1, 8'h00));
    dir_rows.push_back(txt_row(8'hFF, 1'b0, 1, 8'hFF));
    dir_rows.push_back(txt_row(NEWLINE_BYTE, 1'b0, 1, NEWLINE_BYTE));
    dir_rows.push_back(txt_row(8'h00, 1'b1, 0, 8'h00));          // nothing pending
    dir_rows.push_back(txt_row(8'h41, 1'b0, 1, 8'h41));
    dir_rows.push_back(txt_row(8'hFF, 1'b1, 1, NEWLINE_BYTE));   // unterminated line
    // "abc" -> 8 bytes; upper length bits must be ignored
    dir_rows.push_back(cfg_row(CFG_SEARCH_PATTERN, 64'hF0E1_D2C3_B463_6261));
    dir_rows.push_back(cfg_row(CFG_SEARCH_LENGTH, 64'hFFFF_FFFF_FFFF_FFF3));
    dir_rows.push_back(cfg_row(CFG_REPLACEMENT_TEXT, 64'h00FF_7F80_0A41_5AA5));
    dir_rows.push_back(cfg_row(CFG_REPLACEMENT_LENGTH, 64'h8));
    dir_rows.push_back(txt_row(8'h61, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h62, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h63, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h61, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h62, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(NEWLINE_BYTE, 1'b0, -1, 8'h00));
    // zero search length acts as 1, oversize replacement length as 8
    dir_rows.push_back(cfg_row(CFG_SEARCH_LENGTH, 64'h0));
    dir_rows.push_back(cfg_row(CFG_REPLACEMENT_LENGTH, 64'hF));
    dir_rows.push_back(txt_row(8'h61, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h62, 1'b0, -1, 8'h00));
    // newline inside the pattern, then the pattern shrinks with a full-ish window
    dir_rows.push_back(cfg_row(CFG_SEARCH_PATTERN, 64'h6867_6665_6463_0A61));
    dir_rows.push_back(cfg_row(CFG_SEARCH_LENGTH, 64'h8));
    dir_rows.push_back(txt_row(8'h61, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(NEWLINE_BYTE, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h63, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h64, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h65, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h66, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h67, 1'b0, -1, 8'h00));
    dir_rows.push_back(cfg_row(CFG_SEARCH_LENGTH, 64'h2));
    dir_rows.push_back(txt_row(8'h68, 1'b0, -1, 8'h00));
    dir_rows.push_back(txt_row(8'h5A, 1'b1, -1, 8'h00));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(row.idx, row.wdata);
      end else begin
        send_text(row.data, row.eoi, row.n_typed, row.typed);
      end
    end

    // modes: none, sender idle, receiver stall, both
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      program_phase(SLEN_SET[ph], RLEN_SET[ph]);
      text_plan.delete();
      counted     = 0;
      pressure_at = $urandom_range(5, ITEMS_PER_PHASE - 5);
      while (counted < ITEMS_PER_PHASE) begin
        if (text_plan.size() == 0) plan_text();
        req = text_plan.pop_front();
        // hold the input back once until the output side has caught up
        if (counted == pressure_at) begin
          wait_drained();
          pressure_at = ITEMS_PER_PHASE;
        end
        ignored = req.eoi && !line_open;
        send_text(req.data, req.eoi, -1, 8'h00);
        if (!ignored) counted++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests over %0d random phases, %0d register writes, %0d bytes checked",
             items_sent, N_PHASES, cfg_writes, results_checked);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfr_pkg.sv
hdl/sfr_cell.sv
hdl/sfr_outbuf.sv
hdl/stream_find_replace_unit.sv
hdl/sfr_checker.sv
tb/testbench.sv
